// File: design/abip_pkg.sv
// Package for the streaming integer parser.
// Holds the beat types, character and base constants, the parser phases and the digit decoder.
// No dependencies.
package abip_pkg;

  localparam int MAX_CHARS_DEFAULT = 255;

  localparam int VALUE_W  = 32;
  localparam int OFFSET_W = 8;
  localparam int BASE_W   = 6;
  localparam int CHAR_W   = 8;

  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_F = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_F = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;

  localparam logic [BASE_W-1:0] BASE_OCT = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;

  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t CFG_BASE_SETTING = 1'b0;
  localparam cfg_index_t CFG_SIGNED_MODE  = 1'b1;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              first;
  } in_beat_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [OFFSET_W-1:0] end_offset;
  } out_beat_t;

  typedef struct packed {
    logic [BASE_W-1:0] base_setting;
    logic              signed_mode;
  } cfg_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_NUMSTART,
    PH_AFTER0,
    PH_AFTERX,
    PH_DIGITS
  } phase_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  function automatic digit_t digit_of(logic [CHAR_W-1:0] c);
    digit_t d;
    d.ok  = 1'b0;
    d.val = 4'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d.ok  = 1'b1;
      d.val = 4'(c - CH_ZERO);
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      d.ok  = 1'b1;
      d.val = 4'(c - CH_LOWER_A + 8'd10);
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      d.ok  = 1'b1;
      d.val = 4'(c - CH_UPPER_A + 8'd10);
    end
    return d;
  endfunction

endpackage

// File: design/abip_cfg_regs.sv
// Configuration registers of the integer parser: base setting and signed mode.
// Depends on abip_pkg.
module abip_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  abip_pkg::cfg_index_t       cfg_index,
  input  logic [abip_pkg::BASE_W-1:0] cfg_data,
  output abip_pkg::cfg_t             cfg
);
  import abip_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE_SETTING: cfg.base_setting <= cfg_data;
        CFG_SIGNED_MODE:  cfg.signed_mode  <= cfg_data[0];
      endcase
    end
  end

endmodule

// File: design/abip_in_stage.sv
// Input register of the integer parser: captures one character beat and holds it
// until the parsing stage takes it. Depends on abip_pkg.
module abip_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               chr_valid,
  output logic               chr_stall,
  input  abip_pkg::in_beat_t chr_data,
  input  logic               advance,
  output logic               held_valid,
  output abip_pkg::in_beat_t held_beat
);
  import abip_pkg::*;

  logic accept;

  assign chr_stall = held_valid && !advance;
  assign accept    = chr_valid && !chr_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_beat <= chr_data;
    end
  end

endmodule

// File: design/abip_core.sv
// Parsing stage: prefix and base selection, the multiply-add digit accumulator and
// the saturating character count. Depends on abip_pkg.
module abip_core #(
  parameter int MAX_CHARS = abip_pkg::MAX_CHARS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  abip_pkg::in_beat_t  beat,
  input  abip_pkg::cfg_t      cfg,
  output logic                res_fire,
  output abip_pkg::out_beat_t res_beat
);
  import abip_pkg::*;

  localparam int CW = $clog2(MAX_CHARS + 1);
  localparam int XW = (CW > OFFSET_W) ? CW : OFFSET_W;
  localparam logic [CW-1:0] CONS_MAX = CW'(MAX_CHARS);
  localparam logic [XW-1:0] OFFSET_MAX = XW'(255);

  phase_t              phase, phase_next;
  logic [VALUE_W-1:0]  acc, acc_next;
  logic [BASE_W-1:0]   active_base, active_base_next;
  logic                negate, negate_next;
  logic [CW-1:0]       consumed, consumed_next;

  phase_t              ph_cur;
  digit_t              dv;
  logic [BASE_W-1:0]   base_sel;
  logic                do_digit;
  logic                stop;
  logic [XW-1:0]       cons_x;

  function automatic logic [CW-1:0] sat_inc(logic [CW-1:0] c);
    return (c < CONS_MAX) ? c + 1'b1 : c;
  endfunction

  assign ph_cur = beat.first ? PH_NUMSTART : phase;
  assign dv     = digit_of(beat.ch);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      acc         <= '0;
      active_base <= '0;
      negate      <= 1'b0;
      consumed    <= '0;
    end else begin
      phase       <= phase_next;
      acc         <= acc_next;
      active_base <= active_base_next;
      negate      <= negate_next;
      consumed    <= consumed_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    acc_next         = acc;
    active_base_next = active_base;
    negate_next      = negate;
    consumed_next    = consumed;
    base_sel         = active_base;
    do_digit         = 1'b0;
    stop             = 1'b0;
    res_fire         = 1'b0;
    res_beat         = '0;
    cons_x           = '0;
    if (go) begin
      if (beat.first) begin
        acc_next         = '0;
        active_base_next = '0;
        negate_next      = 1'b0;
        consumed_next    = '0;
        phase_next       = PH_NUMSTART;
      end
      if (beat.first && cfg.signed_mode && beat.ch == CH_MINUS) begin
        negate_next   = 1'b1;
        consumed_next = sat_inc(consumed_next);
      end else begin
        unique case (ph_cur)
          PH_IDLE: begin
          end
          PH_NUMSTART: begin
            if (beat.ch == CH_ZERO) begin
              consumed_next = sat_inc(consumed_next);
              phase_next    = PH_AFTER0;
            end else begin
              base_sel   = (cfg.base_setting != '0) ? cfg.base_setting : BASE_DEC;
              phase_next = PH_DIGITS;
              do_digit   = 1'b1;
            end
          end
          PH_AFTER0: begin
            if (beat.ch == CH_LOWER_X || beat.ch == CH_UPPER_X) begin
              phase_next = PH_AFTERX;
            end else begin
              base_sel   = (cfg.base_setting != '0) ? cfg.base_setting : BASE_OCT;
              phase_next = PH_DIGITS;
              do_digit   = 1'b1;
            end
          end
          PH_AFTERX: begin
            if (dv.ok) begin
              base_sel      = BASE_HEX;
              consumed_next = sat_inc(consumed_next);
              phase_next    = PH_DIGITS;
              do_digit      = 1'b1;
            end else begin
              stop = 1'b1;
            end
          end
          PH_DIGITS: begin
            do_digit = 1'b1;
          end
          default: begin
          end
        endcase
        active_base_next = base_sel;
        if (ph_cur == PH_IDLE) begin
          active_base_next = active_base;
        end
        if (do_digit) begin
          if (dv.ok && {2'b00, dv.val} < base_sel) begin
            acc_next      = acc_next * VALUE_W'(base_sel) + VALUE_W'(dv.val);
            consumed_next = sat_inc(consumed_next);
          end else begin
            stop = 1'b1;
          end
        end
        if (stop) begin
          cons_x              = XW'(consumed_next);
          res_fire            = 1'b1;
          res_beat.value      = negate_next ? (VALUE_W'(0) - acc_next) : acc_next;
          res_beat.end_offset = (cons_x > OFFSET_MAX) ? 8'hFF : cons_x[OFFSET_W-1:0];
          phase_next          = PH_IDLE;
        end
      end
    end
  end

endmodule

// File: design/abip_out_stage.sv
// Result register of the integer parser: holds one result beat until it is taken.
// Depends on abip_pkg.
module abip_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                res_fire,
  input  abip_pkg::out_beat_t res_beat,
  output logic                res_valid,
  input  logic                res_stall,
  output abip_pkg::out_beat_t res_data,
  output logic                out_free
);
  import abip_pkg::*;

  assign out_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_fire) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      res_data <= res_beat;
    end
  end

endmodule

// File: design/auto_base_integer_parser_top.sv
// Top level of the streaming strtoul-style integer parser.
// Depends on abip_pkg, abip_cfg_regs, abip_in_stage, abip_core and abip_out_stage.
//
// One character beat is accepted in every cycle while the result side keeps up. The beat
// of the stopping character is held in the input register, where it waits while the result
// register is full and stalled, and its result is then written to the result register; a
// beat that stops nothing yields no result. Input stall rises only while a character waits
// and the result register is full and stalled. Configuration is written through cfg_we,
// cfg_index and cfg_data and takes effect at once.
module auto_base_integer_parser_top #(
  parameter int MAX_CHARS = abip_pkg::MAX_CHARS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  abip_pkg::cfg_index_t        cfg_index,
  input  logic [abip_pkg::BASE_W-1:0] cfg_data,
  input  logic                        chr_valid,
  output logic                        chr_stall,
  input  abip_pkg::in_beat_t          chr_data,
  output logic                        res_valid,
  input  logic                        res_stall,
  output abip_pkg::out_beat_t         res_data
);
  import abip_pkg::*;

  cfg_t      cfg;
  logic      out_free;
  logic      held_valid;
  in_beat_t  held_beat;
  logic      go;
  logic      res_fire;
  out_beat_t res_beat;

  assign go = held_valid && out_free;

  abip_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  abip_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .chr_valid  (chr_valid),
    .chr_stall  (chr_stall),
    .chr_data   (chr_data),
    .advance    (out_free),
    .held_valid (held_valid),
    .held_beat  (held_beat)
  );

  abip_core #(
    .MAX_CHARS (MAX_CHARS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .beat     (held_beat),
    .cfg      (cfg),
    .res_fire (res_fire),
    .res_beat (res_beat)
  );

  abip_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_fire  (res_fire),
    .res_beat  (res_beat),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .out_free  (out_free)
  );

endmodule

// File: design/abip_checker.sv
// Port-level checks for the integer parser, bound to the top level.
// Depends on abip_pkg and auto_base_integer_parser_top.
module abip_checker (
  input logic                clk,
  input logic                rst,
  input logic                chr_valid,
  input logic                chr_stall,
  input logic                res_valid,
  input logic                res_stall,
  input abip_pkg::out_beat_t res_data
);
  import abip_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("A stalled result beat changed or vanished.");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("A result beat was shown straight after reset.");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    chr_stall |-> res_valid && res_stall)
    else $error("Input stalled although the result register could move.");

  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(chr_valid && !chr_stall, 2))
    else $error("A result beat appeared without a character beat two cycles earlier.");

endmodule

bind auto_base_integer_parser_top abip_checker u_chk (.*);
